[hdl/encoder_bank_layer_controller_unit_defines.svh]
`ifndef ENCODER_BANK_LAYER_CONTROLLER_UNIT_DEFINES_SVH
`define ENCODER_BANK_LAYER_CONTROLLER_UNIT_DEFINES_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define EBL_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define EBL_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/ebl_pkg.sv]
package ebl_pkg;

  localparam int MaxChannels = 8;
  localparam int CountW      = 32;
  localparam int TimeW       = 32;
  localparam int MsW         = 16;
  localparam int ValW        = 8;
  localparam int ChanW       = 3;

  localparam int InDataW  = 296;
  localparam int BtnOff   = MaxChannels * CountW;
  localparam int NowOff   = BtnOff + 8;
  localparam int OutDataW = 40;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] RegDebounce    = 3'd0;
  localparam logic [CfgIdxW-1:0] RegDoubleClick = 3'd1;
  localparam logic [CfgIdxW-1:0] RegFlash       = 3'd2;
  localparam logic [CfgIdxW-1:0] RegValueMax    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegLedLevel    = 3'd4;

  localparam logic [MsW-1:0]  DebounceRst    = 16'd30;
  localparam logic [MsW-1:0]  DoubleClickRst = 16'd300;
  localparam logic [MsW-1:0]  FlashRst       = 16'd150;
  localparam logic [ValW-1:0] ValueMaxRst    = 8'd100;
  localparam logic [ValW-1:0] LedLevelRst    = 8'd60;

  typedef struct packed {
    logic [MsW-1:0]  settle_ms;
    logic [MsW-1:0]  double_click_ms;
    logic [MsW-1:0]  flash_ms;
    logic [ValW-1:0] value_max;
    logic [ValW-1:0] led_level;
  } cfg_t;

  typedef struct packed {
    logic            was_reset;
    logic [ValW-1:0] level;
    logic [ValW-1:0] blue;
    logic [ValW-1:0] green;
    logic [ValW-1:0] red;
  } lane_res_t;

endpackage

[hdl/encoder_bank_layer_controller_unit.sv]
// Encoder bank layer controller. One snapshot (eight raw counts, active-low buttons, layer
// select, ms time) is taken per input transfer; CHANNELS lanes update all channel states at
// once, then the results leave one per cycle while m_axis_tready is high, channel 0 first,
// tlast on the final one. A snapshot is held in the input register, then loaded into the
// result bank; sustained throughput is set by the single output port that drains the result
// bank. The next snapshot is accepted while the bank still drains.
// Config writes must only happen while the block is idle.
module encoder_bank_layer_controller_unit
  import ebl_pkg::*;
#(
  parameter int CHANNELS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,  // count_0..count_7, buttons_n, now_ms
  input  logic                s_axis_tuser,  // layer_sel
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,  // red, green, blue, level, was_reset
  output logic [ChanW-1:0]    m_axis_tuser,  // channel
  output logic                m_axis_tlast
);

  cfg_t               cfg_q;
  logic               in_valid_q;
  logic [InDataW-1:0] in_data_q;
  logic               in_layer_q;
  logic               free, move;
  lane_res_t          lane_res [CHANNELS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.settle_ms       <= DebounceRst;
      cfg_q.double_click_ms <= DoubleClickRst;
      cfg_q.flash_ms        <= FlashRst;
      cfg_q.value_max       <= ValueMaxRst;
      cfg_q.led_level       <= LedLevelRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegDebounce:    cfg_q.settle_ms       <= cfg_wdata_i;
        RegDoubleClick: cfg_q.double_click_ms <= cfg_wdata_i;
        RegFlash:       cfg_q.flash_ms        <= cfg_wdata_i;
        RegValueMax:    cfg_q.value_max       <= cfg_wdata_i[ValW-1:0];
        RegLedLevel:    cfg_q.led_level       <= cfg_wdata_i[ValW-1:0];
        default: ;
      endcase
    end
  end

  assign move          = in_valid_q && free;
  assign s_axis_tready = !in_valid_q || free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_data_q  <= s_axis_tdata;
      in_layer_q <= s_axis_tuser;
    end
  end

  for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
    ebl_lane u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (move),
      .count_i (in_data_q[g*CountW +: CountW]),
      .btn_n_i (in_data_q[BtnOff + g]),
      .layer_i (in_layer_q),
      .now_i   (in_data_q[NowOff +: TimeW]),
      .cfg_i   (cfg_q),
      .res_o   (lane_res[g])
    );
  end

  ebl_serializer #(
    .CHANNELS (CHANNELS)
  ) u_ser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (move),
    .res_i         (lane_res),
    .free_o        (free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

[hdl/ebl_lane.sv]
module ebl_lane
  import ebl_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic [CountW-1:0] count_i,
  input  logic              btn_n_i,
  input  logic              layer_i,
  input  logic [TimeW-1:0]  now_i,
  input  cfg_t              cfg_i,
  output lane_res_t         res_o
);

  localparam int SumW = CountW + 2;

  logic [CountW-1:0] prev_count_q;
  logic [ValW-1:0]   value_a_q, value_a_d;
  logic [ValW-1:0]   value_b_q, value_b_d;
  logic [TimeW-1:0]  press_q, press_d;
  logic [TimeW-1:0]  flash_q, flash_d;
  logic              prev_rel_q;

  logic [CountW-1:0] delta;
  logic [ValW-1:0]   val_old, val_rot, val_new;
  logic [SumW-1:0]   sum;
  logic [TimeW-1:0]  elapsed;
  logic              pressed, accept, dbl, flash_on;

  always_comb begin
    delta   = count_i - prev_count_q;
    val_old = layer_i ? value_b_q : value_a_q;
    sum     = SumW'({{(SumW-ValW){1'b0}}, val_old}) + {{2{delta[CountW-1]}}, delta};
    if (delta == '0) begin
      val_rot = val_old;
    end else if (sum[SumW-1]) begin
      val_rot = '0;
    end else if (sum > SumW'(cfg_i.value_max)) begin
      val_rot = cfg_i.value_max;
    end else begin
      val_rot = sum[ValW-1:0];
    end

    pressed = !btn_n_i;
    elapsed = now_i - press_q;
    accept  = pressed && prev_rel_q && (elapsed > TimeW'(cfg_i.settle_ms));
    dbl     = accept && (elapsed < TimeW'(cfg_i.double_click_ms));

    val_new = dbl ? '0 : val_rot;
    press_d = accept ? now_i : press_q;
    flash_d = dbl ? (now_i + TimeW'(cfg_i.flash_ms)) : flash_q;
    flash_on = now_i < flash_d;

    value_a_d = layer_i ? value_a_q : val_new;
    value_b_d = layer_i ? val_new : value_b_q;

    res_o = '0;
    res_o.level     = val_new;
    res_o.was_reset = dbl;
    if (flash_on) begin
      res_o.red   = cfg_i.led_level;
      res_o.green = cfg_i.led_level;
      res_o.blue  = cfg_i.led_level;
    end else if (pressed) begin
      res_o.blue = cfg_i.led_level;
    end else if (layer_i) begin
      res_o.red = val_new;
    end else begin
      res_o.green = val_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_count_q <= '0;
      value_a_q    <= '0;
      value_b_q    <= '0;
      press_q      <= '0;
      flash_q      <= '0;
      prev_rel_q   <= 1'b1;
    end else if (en_i) begin
      prev_count_q <= count_i;
      value_a_q    <= value_a_d;
      value_b_q    <= value_b_d;
      press_q      <= press_d;
      flash_q      <= flash_d;
      prev_rel_q   <= btn_n_i;
    end
  end

endmodule

[hdl/ebl_serializer.sv]
`include "encoder_bank_layer_controller_unit_defines.svh"

module ebl_serializer
  import ebl_pkg::*;
#(
  parameter int CHANNELS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  lane_res_t           res_i [CHANNELS],
  output logic                free_o,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,  // red, green, blue, level, was_reset
  output logic [ChanW-1:0]    m_axis_tuser,  // channel
  output logic                m_axis_tlast
);

  localparam int IdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(CHANNELS - 1);

  lane_res_t       bank_q [CHANNELS];
  logic            busy_q;
  logic [IdxW-1:0] idx_q;
  logic            out_xfer, at_last;

  assign at_last  = idx_q == LastIdx;
  assign out_xfer = busy_q && m_axis_tready;
  assign free_o   = !busy_q || (m_axis_tready && at_last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (load_i) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
    end else if (out_xfer) begin
      if (at_last) begin
        busy_q <= 1'b0;
        idx_q  <= '0;
      end else begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bank_q <= res_i;
    end
  end

  assign m_axis_tvalid = busy_q;
  assign m_axis_tdata  = OutDataW'(bank_q[idx_q]);
  assign m_axis_tuser  = ChanW'(idx_q);
  assign m_axis_tlast  = at_last;

  `EBL_ASSERT_IMP(a_load_when_free, load_i, !busy_q || (m_axis_tready && at_last), "load while busy")
  `EBL_ASSERT_NXT(a_load_starts, load_i, busy_q && idx_q == '0, "load did not start at channel 0")
  `EBL_ASSERT_NXT(a_last_frees, out_xfer && at_last && !load_i, !busy_q, "bank not freed")
  `EBL_ASSERT_NXT(a_idx_steps, out_xfer && !at_last && !load_i,
                  busy_q && idx_q == $past(idx_q) + 1'b1, "channel index skipped")

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import ebl_pkg::*;

  localparam int HoldCycles = 300;
  localparam logic [CfgIdxW-1:0] RegSpareLo = 3'd5;
  localparam logic [CfgIdxW-1:0] RegSpareHi = 3'd7;

  typedef struct packed {
    logic [MaxChannels-1:0][CountW-1:0] count;
    logic [7:0]                         buttons_n;
    logic                               layer_b;
    logic [TimeW-1:0]                   now_ms;
  } snapshot_t;

  typedef struct packed {
    logic [ChanW-1:0] channel;
    lane_res_t        color;
    logic             last;
  } led_due_t;

  class led_color_board;
    logic [MsW-1:0]    debounce, dclick, flash;
    logic [ValW-1:0]   vmax, led;
    logic [CountW-1:0] prev_count [MaxChannels];
    logic [ValW-1:0]   val_a [MaxChannels];
    logic [ValW-1:0]   val_b [MaxChannels];
    logic [TimeW-1:0]  press_t [MaxChannels];
    logic [TimeW-1:0]  flash_end [MaxChannels];
    logic [7:0]        prev_btn;
    led_due_t          led_due_q [$];
    int                errors;
    int                shown;

    function new();
      debounce = DebounceRst;
      dclick   = DoubleClickRst;
      flash    = FlashRst;
      vmax     = ValueMaxRst;
      led      = LedLevelRst;
      for (int i = 0; i < MaxChannels; i++) begin
        prev_count[i] = '0;
        val_a[i]      = '0;
        val_b[i]      = '0;
        press_t[i]    = '0;
        flash_end[i]  = '0;
      end
      prev_btn = 8'hFF;
      errors   = 0;
      shown    = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] d);
      case (idx)
        RegDebounce:    debounce = d;
        RegDoubleClick: dclick   = d;
        RegFlash:       flash    = d;
        RegValueMax:    vmax     = d[ValW-1:0];
        RegLedLevel:    led      = d[ValW-1:0];
        default: ;
      endcase
    endfunction

    function void note_snapshot(snapshot_t s);
      logic [CountW-1:0] diff;
      logic [TimeW-1:0]  elapsed;
      logic [ValW-1:0]   cur;
      longint            sum;
      int                sdiff;
      logic              pressed, held_prev;
      led_due_t          e;
      for (int i = 0; i < MaxChannels; i++) begin
        cur = s.layer_b ? val_b[i] : val_a[i];
        diff = s.count[i] - prev_count[i];
        prev_count[i] = s.count[i];
        e = '0;
        if (diff != 0) begin
          sdiff = $signed(diff);
          sum = longint'(cur) + longint'(sdiff);
          if (sum < 0) sum = 0;
          if (sum > longint'(vmax)) sum = longint'(vmax);
          cur = sum[ValW-1:0];
        end
        pressed   = !s.buttons_n[i];
        held_prev = !prev_btn[i];
        if (pressed && !held_prev) begin
          elapsed = s.now_ms - press_t[i];
          if (elapsed > {16'b0, debounce}) begin
            if (elapsed < {16'b0, dclick}) begin
              cur = '0;
              flash_end[i] = s.now_ms + {16'b0, flash};
              e.color.was_reset = 1'b1;
            end
            press_t[i] = s.now_ms;
          end
        end
        if (s.layer_b) val_b[i] = cur;
        else val_a[i] = cur;
        if (s.now_ms < flash_end[i]) begin
          e.color.red   = led;
          e.color.green = led;
          e.color.blue  = led;
        end else if (pressed) begin
          e.color.blue = led;
        end else if (s.layer_b) begin
          e.color.red = cur;
        end else begin
          e.color.green = cur;
        end
        e.color.level = cur;
        e.channel = i[ChanW-1:0];
        e.last = (i == MaxChannels - 1);
        led_due_q.push_back(e);
      end
      prev_btn = s.buttons_n;
    endfunction

    function int pending();
      return led_due_q.size();
    endfunction

    function void check_led(logic [OutDataW-1:0] data, logic [ChanW-1:0] chan, logic last);
      lane_res_t got;
      led_due_t  e;
      got = data[$bits(lane_res_t)-1:0];
      if (led_due_q.size() == 0) begin
        errors++;
        if (shown < 10) begin
          $display("unexpected result: ch %0d data %h last %b", chan, data, last);
          shown++;
        end
        return;
      end
      e = led_due_q.pop_front();
      if (chan !== e.channel || got.red !== e.color.red || got.green !== e.color.green ||
          got.blue !== e.color.blue || got.level !== e.color.level ||
          got.was_reset !== e.color.was_reset || last !== e.last ||
          data[OutDataW-1:$bits(lane_res_t)] !== '0) begin
        errors++;
        if (shown < 10) begin
          $display("mismatch exp: ch %0d r %0d g %0d b %0d lvl %0d clr %b last %b",
                   e.channel, e.color.red, e.color.green, e.color.blue, e.color.level,
                   e.color.was_reset, e.last);
          $display("         act: ch %0d r %0d g %0d b %0d lvl %0d clr %b last %b pad %h",
                   chan, got.red, got.green, got.blue, got.level, got.was_reset, last,
                   data[OutDataW-1:$bits(lane_res_t)]);
          shown++;
        end
      end
    endfunction
  endclass

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i     = '0;
  logic [CfgDataW-1:0] cfg_wdata_i   = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                s_axis_tuser  = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [ChanW-1:0]    m_axis_tuser;
  logic                m_axis_tlast;

  led_color_board sb = new();

  logic [MaxChannels-1:0][CountW-1:0] cur_count = '0;
  logic [7:0]       cur_btn   = 8'hFF;
  logic             cur_layer = 1'b0;
  logic [TimeW-1:0] cur_now   = '0;

  bit tx_no_idle = 1'b0;
  bit rx_no_idle = 1'b0;
  bit hold_req   = 1'b0;
  bit hold_done  = 1'b0;
  int rx_gap     = 0;

  encoder_bank_layer_controller_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #(20_000_000);
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic int pick_gap(bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // receiver: random backpressure, plus one long hold on request
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_done) begin
        m_axis_tready = 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_done = 1'b1;
      end else if (rx_gap > 0) begin
        m_axis_tready = 1'b0;
        rx_gap--;
      end else begin
        m_axis_tready = 1'b1;
        rx_gap = pick_gap(rx_no_idle);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_led(m_axis_tdata, m_axis_tuser, m_axis_tlast);
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_current();
    snapshot_t s;
    int gap;
    s.count     = cur_count;
    s.buttons_n = cur_btn;
    s.layer_b   = cur_layer;
    s.now_ms    = cur_now;
    gap = pick_gap(tx_no_idle);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    for (int i = 0; i < MaxChannels; i++) s_axis_tdata[i*CountW +: CountW] = s.count[i];
    s_axis_tdata[BtnOff +: 8]    = s.buttons_n;
    s_axis_tdata[NowOff +: TimeW] = s.now_ms;
    s_axis_tuser = s.layer_b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_snapshot(s);
    @(negedge clk_i);
  endtask

  task automatic put(logic [7:0] btn, logic layer, logic [TimeW-1:0] now);
    cur_btn   = btn;
    cur_layer = layer;
    cur_now   = now;
    send_current();
  endtask

  task automatic step_random();
    int r, d;
    r = $urandom_range(0, 99);
    if (r < 80) begin
      r = $urandom_range(0, 9);
      if (r < 4) cur_now += $urandom_range(0, 40);
      else if (r < 8) cur_now += $urandom_range(0, 400);
      else cur_now += $urandom_range(0, 70000);
      for (int i = 0; i < MaxChannels; i++) begin
        r = $urandom_range(0, 19);
        if (r >= 7) begin
          d = (r < 17) ? $urandom_range(0, 8) : $urandom_range(0, 300);
          if ($urandom_range(0, 1)) d = -d;
          cur_count[i] = cur_count[i] + d;
        end
        if ($urandom_range(0, 9) < 4) cur_btn[i] = ~cur_btn[i];
      end
      if ($urandom_range(0, 9) == 0) cur_layer = ~cur_layer;
    end else begin
      for (int i = 0; i < MaxChannels; i++)
        if ($urandom_range(0, 1)) cur_count[i] = $urandom;
      if ($urandom_range(0, 3) == 0) cur_now = 32'hFFFF_FFFF - $urandom_range(0, 300);
      else cur_now = $urandom;
      cur_btn   = 8'($urandom);
      cur_layer = 1'($urandom_range(0, 1));
    end
    send_current();
  endtask

  task automatic run_phase(int n);
    repeat (n) step_random();
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    s_axis_tvalid = 1'b0;
    while (sb.pending() != 0 && guard < 20000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] d);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = d;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.set_reg(idx, d);
    @(negedge clk_i);
  endtask

  task automatic set_all(logic [15:0] deb, logic [15:0] dc, logic [15:0] fl,
                         logic [15:0] vm, logic [15:0] ld);
    write_reg(RegDebounce, deb);
    write_reg(RegDoubleClick, dc);
    write_reg(RegFlash, fl);
    write_reg(RegValueMax, vm);
    write_reg(RegLedLevel, ld);
    write_reg(RegSpareLo, 16'($urandom_range(0, 65535)));
    write_reg(RegSpareHi, 16'($urandom_range(0, 65535)));
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset settings: clamps, layers, debounce, double click, flash, wraps
    put(8'hFF, 1'b0, 32'd0);
    cur_count[0] = 32'd5;
    cur_count[1] = 32'hFFFF_FFFD;
    cur_count[2] = 32'd250;
    cur_count[3] = 32'h7FFF_FFFF;
    cur_count[4] = 32'h8000_0000;
    cur_count[5] = 32'd1;
    cur_count[6] = 32'hFFFF_FFFF;
    cur_count[7] = 32'd100;
    put(8'hFF, 1'b0, 32'd10);
    for (int i = 0; i < MaxChannels; i++) cur_count[i] = cur_count[i] + i + 1;
    put(8'hFF, 1'b1, 32'd15);
    put(8'h00, 1'b1, 32'd20);
    put(8'hFF, 1'b1, 32'd25);
    put(8'h00, 1'b0, 32'd100);
    put(8'h00, 1'b0, 32'd200);
    put(8'hFF, 1'b0, 32'd260);
    put(8'h00, 1'b0, 32'd700);
    put(8'hFF, 1'b0, 32'd720);
    put(8'h00, 1'b1, 32'd740);
    put(8'hFF, 1'b1, 32'd745);
    put(8'h00, 1'b1, 32'd750);
    put(8'hFF, 1'b1, 32'd760);
    put(8'h00, 1'b0, 32'd1000);
    cur_count[3] = 32'h8000_0000;
    cur_count[4] = 32'h7FFF_FFFF;
    put(8'hFF, 1'b0, 32'd1010);
    for (int i = 0; i < MaxChannels; i++) cur_count[i] = 32'h8000_0000;
    put(8'hFF, 1'b1, 32'd1020);
    for (int i = 0; i < MaxChannels; i++) cur_count[i] = 32'h7FFF_FFFF;
    put(8'hFF, 1'b1, 32'd1030);
    put(8'hFF, 1'b0, 32'hFFFF_FF00);
    put(8'h00, 1'b0, 32'hFFFF_FF40);
    put(8'hFF, 1'b0, 32'hFFFF_FF50);
    put(8'h00, 1'b0, 32'hFFFF_FF80);
    put(8'hFF, 1'b0, 32'h0000_0010);
    put(8'h5A, 1'b0, 32'h0000_0100);

    run_phase(48);

    drain();
    set_all(16'h0000, 16'h0000, 16'h0000, 16'hFF00, 16'hFF00);
    run_phase(48);

    drain();
    set_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_phase(48);

    // long receiver hold while the sender keeps pushing
    drain();
    set_all(16'd5, 16'd200, 16'd100, 16'h00FF, 16'($urandom_range(0, 65535)));
    tx_no_idle = 1'b1;
    hold_req   = 1'b1;
    run_phase(24);
    tx_no_idle = 1'b0;
    run_phase(24);

    drain();
    set_all(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
            16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
            16'($urandom_range(0, 65535)));
    tx_no_idle = 1'b1;
    rx_no_idle = 1'b1;
    run_phase(48);
    tx_no_idle = 1'b0;
    rx_no_idle = 1'b0;

    // lowered max: values above it stay put without rotation
    drain();
    set_all(16'd30, 16'd1000, 16'd500, 16'd50, 16'd200);
    run_phase(48);

    drain();
    set_all(16'($urandom_range(0, 400)), 16'($urandom_range(0, 2000)),
            16'($urandom_range(0, 1000)), 16'($urandom_range(0, 65535)),
            16'($urandom_range(0, 65535)));
    run_phase(48);

    drain();
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
